// File: rtl/core/kmer_inverted_index_builder_core_macros.svh
// Assertion macros shared by the core.
`ifndef KMER_INVERTED_INDEX_BUILDER_CORE_MACROS_SVH
`define KMER_INVERTED_INDEX_BUILDER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define KIB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kib check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define KIB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kib check failed");
`endif

// File: rtl/core/kib_pkg.sv
`default_nettype none
package kib_pkg;
	localparam int unsigned MaxKmers    = 65536;
	localparam int unsigned MaxSeqs     = 4096;
	localparam int unsigned ListDepth   = 262144;
	localparam int unsigned BitmapSlots = 64;
	localparam int unsigned KmerW  = $clog2(MaxKmers);
	localparam int unsigned SeqIdxW = $clog2(MaxSeqs);
	localparam int unsigned ListW  = $clog2(ListDepth);
	localparam int unsigned SlotW  = $clog2(BitmapSlots + 1);
	localparam int unsigned WordsPerSlot = (MaxSeqs + 63) / 64;
	localparam int unsigned WordAddrW = $clog2(BitmapSlots * WordsPerSlot);
	localparam int unsigned CntW = 13;
	localparam logic [CntW-1:0] CounterMax = 13'd8191;

	localparam logic [2:0] OpCount = 3'd0;
	localparam logic [2:0] OpFinal = 3'd1;
	localparam logic [2:0] OpAdd   = 3'd2;
	localparam logic [2:0] OpEnd   = 3'd3;
	localparam logic [2:0] OpQuery = 3'd4;
	localparam logic [2:0] OpRdEnt = 3'd5;
	localparam logic [2:0] OpRdMap = 3'd6;

	localparam logic [1:0] StOk   = 2'd0;
	localparam logic [1:0] StList = 2'd1;
	localparam logic [1:0] StSlot = 2'd2;
	localparam logic [1:0] StBad  = 2'd3;

	localparam logic [1:0] CfgUseBitmap  = 2'd0;
	localparam logic [1:0] CfgWordLength = 2'd1;
	localparam logic [1:0] CfgSeqCount   = 2'd2;

	// One entry of the k-mer table: counter, list start, slot.
	typedef struct packed {
		logic [CntW-1:0]  cnt;
		logic [ListW:0]   start;
		logic [SlotW-1:0] slot;
	} kentry_t;
	localparam int unsigned EntryW = $bits(kentry_t);
endpackage
`default_nettype wire

// File: rtl/core/kmer_inverted_index_builder_core.sv
// The result beat is registered after the read, execute, second read and second execute
// states. FINALIZE walks the larger of the table size and the largest table touched
// since the last one, then clears the bitmap. A new item is taken at the edge that
// accepts the previous result beat, so items never overlap.
// After reset a clearing pass sweeps the k-mer table, busy high.
// An item is taken only while busy is low; the receiver cannot stall the result.
`default_nettype none
`include "kmer_inverted_index_builder_core_macros.svh"
module kmer_inverted_index_builder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] kmer,
	input  wire logic [11:0] position,
	input  wire logic [23:0] seq_number,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [23:0]      value,
	output logic             uses_bitmap,
	output logic [18:0]      list_offset,
	output logic             member_bit
);
	localparam int unsigned KW = kib_pkg::KmerW;
	localparam int unsigned LW = kib_pkg::ListW;
	localparam int unsigned SW = kib_pkg::SlotW;
	localparam int unsigned EW = kib_pkg::SeqIdxW;
	localparam int unsigned WAW = kib_pkg::WordAddrW;
	localparam int unsigned CW = kib_pkg::CntW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_EXEC, S_RD2, S_EXEC2, S_FWALK, S_FLAST, S_FCLR, S_FDONE
	} state_t;
	state_t state_q;

	// Configuration registers.
	logic use_bitmap_q;
	logic [3:0] word_length_q;
	logic [12:0] seq_count_q;

	// Item registers.
	logic [2:0] op_q;
	logic [15:0] kmer_q;
	logic [11:0] pos_q;
	logic [23:0] seqno_q;

	// Global state.
	logic [EW:0] elem_q;
	logic [SW-1:0] slots_q;
	logic [LW:0] total_q;
	logic finalized_q;
	logic [KW:0] walk_q;
	logic list_short_q, slot_short_q;
	logic [13:0] thr_q;
	logic [WAW:0] clr_q;
	logic [WAW-1:0] b_raddr_q;
	logic [LW-1:0] l_raddr_q;

	// Memories.
	logic t_we; logic [KW-1:0] t_waddr, t_raddr;
	kib_pkg::kentry_t t_wdata, t_rdata;
	logic [kib_pkg::EntryW-1:0] t_rraw;
	kib_ram #(.Width(kib_pkg::EntryW), .Depth(kib_pkg::MaxKmers)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr),
		.rdata(t_rraw));
	assign t_rdata = kib_pkg::kentry_t'(t_rraw);

	logic b_we; logic [WAW-1:0] b_waddr, b_raddr; logic [63:0] b_wdata, b_rdata;
	kib_ram #(.Width(64), .Depth(kib_pkg::BitmapSlots * kib_pkg::WordsPerSlot)) u_bitmap (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr),
		.rdata(b_rdata));

	logic l_we; logic [LW-1:0] l_waddr, l_raddr; logic [11:0] l_wdata, l_rdata;
	kib_ram #(.Width(12), .Depth(kib_pkg::ListDepth)) u_list (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr),
		.rdata(l_rdata));

	logic m_we; logic [EW-1:0] m_waddr, m_raddr; logic [23:0] m_wdata, m_rdata;
	kib_ram #(.Width(24), .Depth(kib_pkg::MaxSeqs)) u_map (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr),
		.rdata(m_rdata));

	// Table size and range test.
	logic [KW:0] tsize;
	always_comb begin
		if (word_length_q >= 4'd8) begin
			tsize = (KW+1)'(kib_pkg::MaxKmers);
		end else begin
			tsize = (KW+1)'(1) << {word_length_q, 1'b0};
		end
	end
	logic kin;
	assign kin = {1'b0, kmer_q} < 17'(tsize);

	// Entries at or above the high-water mark hold a zero count and no slot, so the
	// finalise walk covers the larger of the table and that mark.
	logic [KW:0] hw_q, span, span_m1;
	logic [KW-1:0] wend_q;
	assign span = (tsize > hw_q) ? tsize : hw_q;
	assign span_m1 = span - (KW+1)'(1);

	// Entry held between the read and second stage.
	kib_pkg::kentry_t ent_q;
	logic [LW:0] addr_sum;
	assign addr_sum = t_rdata.start + (LW+1)'(t_rdata.cnt);
	logic [LW:0] rd_sum;
	assign rd_sum = t_rdata.start + (LW+1)'(pos_q);
	logic [WAW-1:0] elem_word, pos_word;
	assign elem_word = WAW'((WAW+6)'(t_rdata.slot - SW'(1)) * (WAW+6)'(kib_pkg::WordsPerSlot)
		+ (WAW+6)'(elem_q[EW-1:0] >> 6));
	assign pos_word = WAW'((WAW+6)'(t_rdata.slot - SW'(1)) * (WAW+6)'(kib_pkg::WordsPerSlot)
		+ (WAW+6)'(pos_q >> 6));
	logic [5:0] bit_q;

	// Finalise walk arithmetic on the entry read last cycle.
	logic frequent;
	assign frequent = {1'b0, t_rdata.cnt} >= thr_q;
	logic [LW+1:0] run_sum;
	assign run_sum = (LW+2)'(total_q) + (LW+2)'(t_rdata.cnt);
	logic [KW-1:0] wprev_q;
	logic in_tab;
	assign in_tab = {1'b0, wprev_q} < tsize;

	// Memory ports.
	always_comb begin
		t_we = 1'b0; t_waddr = kmer_q[KW-1:0]; t_wdata = ent_q; t_raddr = kmer[KW-1:0];
		b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
		l_we = 1'b0; l_waddr = '0; l_wdata = elem_q[11:0]; l_raddr = '0;
		m_we = 1'b0; m_waddr = elem_q[EW-1:0]; m_wdata = seqno_q; m_raddr = pos_q[EW-1:0];
		case (state_q)
			S_CLEAR: begin
				t_we = 1'b1; t_waddr = walk_q[KW-1:0]; t_wdata = '0;
			end
			S_IDLE: begin
				t_raddr = kmer[KW-1:0];
			end
			S_RD: begin
				t_raddr = kmer_q[KW-1:0];
			end
			S_EXEC: begin
				b_raddr = (op_q == kib_pkg::OpAdd) ? elem_word : pos_word;
				l_raddr = rd_sum[LW-1:0];
				if (kin && op_q == kib_pkg::OpCount) begin
					t_we = 1'b1;
					t_wdata = t_rdata;
					if (t_rdata.cnt < kib_pkg::CounterMax) t_wdata.cnt = t_rdata.cnt + CW'(1);
				end
				if (op_q == kib_pkg::OpEnd && elem_q < (EW+1)'(kib_pkg::MaxSeqs)) begin
					m_we = 1'b1;
				end
				if (op_q == kib_pkg::OpAdd && kin && finalized_q
						&& elem_q < (EW+1)'(kib_pkg::MaxSeqs)) begin
					t_we = 1'b1;
					t_wdata = t_rdata;
					if (t_rdata.slot != '0) begin
						if (t_rdata.cnt < kib_pkg::CounterMax) t_wdata.cnt = t_rdata.cnt + CW'(1);
					end else if (t_rdata.cnt < kib_pkg::CounterMax
							&& addr_sum < (LW+1)'(kib_pkg::ListDepth)) begin
						t_wdata.cnt = t_rdata.cnt + CW'(1);
						l_we = 1'b1; l_waddr = addr_sum[LW-1:0];
					end
				end
			end
			S_RD2: begin
				// Hold the read addresses so the data stays valid into the last stage.
				b_raddr = b_raddr_q;
				l_raddr = l_raddr_q;
			end
			S_EXEC2: begin
				if (op_q == kib_pkg::OpAdd && status != kib_pkg::StBad && ent_q.slot != '0) begin
					b_we = 1'b1; b_waddr = b_raddr_q;
					b_wdata = b_rdata | (64'd1 << bit_q);
				end
			end
			S_FWALK, S_FLAST: begin
				t_raddr = walk_q[KW-1:0];
				if (state_q == S_FLAST || walk_q != '0) begin
					t_we = 1'b1; t_waddr = wprev_q;
					t_wdata.cnt = '0;
					t_wdata.start = t_rdata.start;
					t_wdata.slot = '0;
					if (in_tab) begin
						t_wdata.start = total_q;
						if (frequent && slots_q < SW'(kib_pkg::BitmapSlots)) begin
							t_wdata.slot = slots_q + SW'(1);
						end
					end
				end
			end
			S_FCLR: begin
				b_we = 1'b1; b_waddr = clr_q[WAW-1:0]; b_wdata = '0;
			end
			default: ;
		endcase
	end

	// Control and result sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; use_bitmap_q <= 1'b1; word_length_q <= 4'd8;
			seq_count_q <= '0; elem_q <= '0; slots_q <= '0; total_q <= '0;
			finalized_q <= 1'b0; walk_q <= '0; done <= 1'b0; status <= '0; value <= '0;
			uses_bitmap <= 1'b0; list_offset <= '0; member_bit <= 1'b0;
			list_short_q <= 1'b0; slot_short_q <= 1'b0; thr_q <= '0; clr_q <= '0;
			op_q <= '0; kmer_q <= '0; pos_q <= '0; seqno_q <= '0; ent_q <= '0;
			bit_q <= '0; b_raddr_q <= '0; l_raddr_q <= '0; wprev_q <= '0;
			hw_q <= '0; wend_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					kib_pkg::CfgUseBitmap:  use_bitmap_q <= cfg_data[0];
					kib_pkg::CfgWordLength: word_length_q <= cfg_data[3:0];
					kib_pkg::CfgSeqCount:   seq_count_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == (KW+1)'(kib_pkg::MaxKmers - 1)) begin
						walk_q <= '0; state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q <= opcode; kmer_q <= kmer; pos_q <= position; seqno_q <= seq_number;
						if (tsize > hw_q) hw_q <= tsize;
						if (opcode == kib_pkg::OpFinal) begin
							thr_q <= use_bitmap_q ? 14'(seq_count_q >> 3) : 14'(seq_count_q) + 14'd1;
							slots_q <= '0; total_q <= '0; list_short_q <= 1'b0;
							slot_short_q <= 1'b0; walk_q <= '0; wend_q <= span_m1[KW-1:0];
							state_q <= S_FWALK;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					ent_q <= t_rdata;
					bit_q <= (op_q == kib_pkg::OpAdd) ? elem_q[5:0] : pos_q[5:0];
					b_raddr_q <= b_raddr;
					l_raddr_q <= l_raddr;
					status <= kib_pkg::StOk; value <= '0; uses_bitmap <= 1'b0;
					list_offset <= '0; member_bit <= 1'b0;
					state_q <= S_RD2;
					case (op_q)
						kib_pkg::OpCount: begin
							if (!kin) status <= kib_pkg::StBad;
							else value <= 24'((t_rdata.cnt < kib_pkg::CounterMax)
								? t_rdata.cnt + CW'(1) : t_rdata.cnt);
						end
						kib_pkg::OpAdd: begin
							if (!kin || !finalized_q || elem_q >= (EW+1)'(kib_pkg::MaxSeqs)) begin
								status <= kib_pkg::StBad;
							end else begin
								uses_bitmap <= t_rdata.slot != '0;
								list_offset <= t_rdata.start;
								value <= 24'(t_rdata.cnt);
								if (t_rdata.slot != '0) begin
									if (t_rdata.cnt < kib_pkg::CounterMax)
										value <= 24'(t_rdata.cnt + CW'(1));
								end else if (t_rdata.cnt < kib_pkg::CounterMax
										&& addr_sum < (LW+1)'(kib_pkg::ListDepth)) begin
									value <= 24'(t_rdata.cnt + CW'(1));
								end else begin
									status <= kib_pkg::StList;
								end
							end
						end
						kib_pkg::OpEnd: begin
							if (elem_q >= (EW+1)'(kib_pkg::MaxSeqs)) status <= kib_pkg::StBad;
							else begin
								value <= 24'(elem_q); elem_q <= elem_q + 1'b1;
							end
						end
						kib_pkg::OpQuery: begin
							if (!kin) status <= kib_pkg::StBad;
							else begin
								value <= 24'(t_rdata.cnt); uses_bitmap <= t_rdata.slot != '0;
								list_offset <= t_rdata.start;
							end
						end
						kib_pkg::OpRdEnt: begin
							if (!kin || !finalized_q) status <= kib_pkg::StBad;
							else if (t_rdata.slot != '0) begin
								uses_bitmap <= 1'b1; list_offset <= t_rdata.start;
							end else if (13'(pos_q) >= t_rdata.cnt
									|| rd_sum >= (LW+1)'(kib_pkg::ListDepth)) begin
								status <= kib_pkg::StBad;
							end else list_offset <= t_rdata.start;
						end
						kib_pkg::OpRdMap: begin
							if ((EW+1)'(pos_q) >= elem_q) status <= kib_pkg::StBad;
						end
						default: status <= kib_pkg::StBad;
					endcase
				end
				S_RD2: state_q <= S_EXEC2;
				S_EXEC2: begin
					done <= 1'b1; state_q <= S_IDLE;
					if (status != kib_pkg::StBad) begin
						if (op_q == kib_pkg::OpRdEnt && !uses_bitmap) value <= 24'(l_rdata);
						if (op_q == kib_pkg::OpRdMap) value <= m_rdata;
						if ((op_q == kib_pkg::OpQuery || op_q == kib_pkg::OpRdEnt)
								&& ent_q.slot != '0) begin
							member_bit <= b_rdata[bit_q];
						end
					end
				end
				S_FWALK, S_FLAST: begin
					wprev_q <= walk_q[KW-1:0];
					if ((state_q == S_FLAST || walk_q != '0) && in_tab) begin
						if (frequent && slots_q < SW'(kib_pkg::BitmapSlots)) begin
							slots_q <= slots_q + SW'(1);
						end else begin
							if (frequent) slot_short_q <= 1'b1;
							if (run_sum > (LW+2)'(kib_pkg::ListDepth)) begin
								total_q <= (LW+1)'(kib_pkg::ListDepth); list_short_q <= 1'b1;
							end else total_q <= run_sum[LW:0];
						end
					end
					if (state_q == S_FLAST) begin
						clr_q <= '0; state_q <= S_FCLR;
					end else if (walk_q[KW-1:0] == wend_q) state_q <= S_FLAST;
					else walk_q <= walk_q + 1'b1;
				end
				S_FCLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (WAW+1)'(kib_pkg::BitmapSlots * kib_pkg::WordsPerSlot - 1))
						state_q <= S_FDONE;
				end
				S_FDONE: begin
					done <= 1'b1; state_q <= S_IDLE; finalized_q <= 1'b1; elem_q <= '0;
					hw_q <= tsize;
					status <= list_short_q ? kib_pkg::StList
						: (slot_short_q ? kib_pkg::StSlot : kib_pkg::StOk);
					value <= 24'(total_q); uses_bitmap <= 1'b0; list_offset <= '0;
					member_bit <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;

	`KIB_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`KIB_ASSERT_IMP(a_done_idle, done, !busy)
	`KIB_ASSERT_IMP(a_bad_clean, done && status == kib_pkg::StBad, value == '0 && !member_bit)
endmodule
`default_nettype wire

// File: rtl/core/kib_ram.sv
`default_nettype none
module kib_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];

	// One write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: tb/kmer_inverted_index_builder_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module kmer_inverted_index_builder_core_tb;
	import kib_pkg::*;

	localparam int unsigned CycleLimit = 20000000;
	localparam int unsigned ItemTarget = 1500;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] kmer;
		logic [11:0] pos;
		logic [23:0] seqno;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] value;
		logic        ub;
		logic [18:0] off;
		logic        mb;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  opcode = '0;
	logic [15:0] kmer = '0;
	logic [11:0] position = '0;
	logic [23:0] seq_number = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        busy, done, uses_bitmap, member_bit;
	logic [1:0]  status;
	logic [23:0] value;
	logic [18:0] list_offset;

	kmer_inverted_index_builder_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .kmer(kmer), .position(position), .seq_number(seq_number),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .status(status), .value(value), .uses_bitmap(uses_bitmap),
		.list_offset(list_offset), .member_bit(member_bit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the index state.
	logic            cfg_ub;
	logic [3:0]      cfg_wl;
	logic [12:0]     cfg_sc;
	logic [12:0]     kcount [MaxKmers];
	logic [18:0]     kstart [MaxKmers];
	logic [6:0]      kslot [MaxKmers];
	logic [63:0]     bitmap [BitmapSlots * 64];
	logic [11:0]     lstore [ListDepth];
	logic [23:0]     elem_seq [MaxSeqs];
	int unsigned     elem_no, slots_taken;
	bit              built;

	item_t   pending_items [$];
	answer_t awaited [$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit          no_idle = 1'b0;

	function automatic int unsigned table_entries(logic [3:0] wl);
		return (wl >= 4'd8) ? MaxKmers : (1 << (2 * wl));
	endfunction

	function automatic logic member(int unsigned sl, int unsigned e);
		if (sl == 0)
			return 1'b0;
		return bitmap[(sl - 1) * 64 + (e >> 6)][e & 63];
	endfunction

	// Assign bitmap slots and list offsets, then clear the counters.
	function automatic answer_t build_table();
		answer_t r;
		int unsigned thr, ts, sum;
		bit list_short, slot_short;
		r = '0;
		thr = cfg_ub ? cfg_sc / 8 : cfg_sc + 1;
		ts = table_entries(cfg_wl);
		sum = 0;
		list_short = 0;
		slot_short = 0;
		slots_taken = 0;
		foreach (kslot[i])
			kslot[i] = '0;
		for (int unsigned i = 0; i < ts; i++) begin
			kstart[i] = sum;
			if (kcount[i] >= thr && slots_taken < BitmapSlots) begin
				for (int w = 0; w < 64; w++)
					bitmap[slots_taken * 64 + w] = '0;
				slots_taken++;
				kslot[i] = slots_taken;
			end else begin
				if (kcount[i] >= thr)
					slot_short = 1;
				if (sum + kcount[i] > ListDepth) begin
					sum = ListDepth;
					list_short = 1;
				end else begin
					sum += kcount[i];
				end
			end
		end
		foreach (kcount[i])
			kcount[i] = '0;
		elem_no = 0;
		built = 1;
		r.value = sum;
		r.status = list_short ? StList : (slot_short ? StSlot : StOk);
		return r;
	endfunction

	function automatic answer_t index_step(item_t it);
		answer_t r;
		bit kin;
		int unsigned sl, st, addr, k;
		r = '0;
		k = it.kmer;
		kin = k < table_entries(cfg_wl);
		sl = kin ? kslot[k] : 0;
		st = kin ? kstart[k] : 0;
		case (it.op)
			OpCount: begin
				if (!kin) begin
					r.status = StBad;
				end else begin
					if (kcount[k] < CounterMax)
						kcount[k]++;
					r.value = kcount[k];
				end
			end
			OpFinal: r = build_table();
			OpAdd: begin
				if (!kin || !built || elem_no >= MaxSeqs) begin
					r.status = StBad;
				end else begin
					r.ub = sl != 0;
					r.off = st;
					if (sl != 0) begin
						bitmap[(sl - 1) * 64 + (elem_no >> 6)][elem_no & 63] = 1'b1;
						if (kcount[k] < CounterMax)
							kcount[k]++;
					end else begin
						addr = st + kcount[k];
						if (kcount[k] >= CounterMax || addr >= ListDepth) begin
							r.status = StList;
						end else begin
							lstore[addr] = elem_no[11:0];
							kcount[k]++;
						end
					end
					r.value = kcount[k];
				end
			end
			OpEnd: begin
				if (elem_no >= MaxSeqs) begin
					r.status = StBad;
				end else begin
					elem_seq[elem_no] = it.seqno;
					r.value = elem_no;
					elem_no++;
				end
			end
			OpQuery: begin
				if (!kin) begin
					r.status = StBad;
				end else begin
					r.value = kcount[k];
					r.ub = sl != 0;
					r.off = st;
					r.mb = member(sl, it.pos);
				end
			end
			OpRdEnt: begin
				if (!kin || !built) begin
					r.status = StBad;
				end else if (sl != 0) begin
					r.ub = 1'b1;
					r.off = st;
					r.mb = member(sl, it.pos);
				end else if (it.pos >= kcount[k] || st + it.pos >= ListDepth) begin
					r.status = StBad;
				end else begin
					r.value = lstore[st + it.pos];
					r.off = st;
				end
			end
			OpRdMap: begin
				if (it.pos >= elem_no)
					r.status = StBad;
				else
					r.value = elem_seq[it.pos];
			end
			default: r.status = StBad;
		endcase
		return r;
	endfunction

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Acceptance, prediction and result checking at the rising edge.
	bit      taken = 1'b0;
	answer_t got, want;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (done) begin
				got = '{status, value, uses_bitmap, list_offset, member_bit};
				if (awaited.size() == 0) begin
					report("result beat with nothing awaited");
				end else begin
					want = awaited.pop_front();
					if (got.status !== want.status)
						report($sformatf("status %0d, wanted %0d", got.status, want.status));
					if (got.value !== want.value)
						report($sformatf("value %0h, wanted %0h", got.value, want.value));
					if (got.ub !== want.ub)
						report($sformatf("uses_bitmap %b, wanted %b", got.ub, want.ub));
					if (got.off !== want.off)
						report($sformatf("list_offset %0h, wanted %0h", got.off, want.off));
					if (got.mb !== want.mb)
						report($sformatf("member_bit %b, wanted %b", got.mb, want.mb));
				end
			end
			if (start && !busy)
				awaited.push_back(index_step('{opcode, kmer, position, seq_number}));
			taken <= start && !busy;
		end
	end

	// Item driver at the falling edge, with random idle bursts.
	int unsigned idle_left = 0;
	item_t       next_item;
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
				// Beat not yet taken: hold it.
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (!no_idle && pending_items.size() > 0 && $urandom_range(5) == 0) begin
				start <= 1'b0;
				idle_left <= $urandom_range(6);
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				start <= 1'b1;
				opcode <= next_item.op;
				kmer <= next_item.kmer;
				position <= next_item.pos;
				seq_number <= next_item.seqno;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("kmer_inverted_index_builder_core verification failed");
			$finish;
		end
	end

	// Stimulus bookkeeping: how far list starts have been written.
	int unsigned written_upto = 0;
	bit          gen_built = 0;
	int unsigned queued = 0;

	task automatic queue_item(input logic [2:0] op, input logic [15:0] k,
			input logic [11:0] p, input logic [23:0] s);
		int unsigned ts;
		ts = table_entries(cfg_wl);
		// A list start that was never written must not be read.
		if ((op == OpQuery || ((op == OpAdd || op == OpRdEnt) && gen_built))
				&& k < ts && k >= written_upto) begin
			if (written_upto > 0)
				k = $urandom_range(written_upto - 1);
			else
				op = OpCount;
		end
		if (op == OpFinal) begin
			gen_built = 1;
			if (ts > written_upto)
				written_upto = ts;
		end
		pending_items.push_back('{op, k, p, s});
		queued++;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || awaited.size() != 0 || start || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgUseBitmap:  cfg_ub = data[0];
			CfgWordLength: cfg_wl = data[3:0];
			CfgSeqCount:   cfg_sc = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic ub, input logic [3:0] wl, input logic [12:0] sc);
		write_reg(CfgUseBitmap, {12'($urandom), ub});
		write_reg(CfgWordLength, {9'($urandom), wl});
		write_reg(CfgSeqCount, sc);
	endtask

	// One build: count pass, finalize, add pass, then reads and some noise.
	task automatic build_phase(input int unsigned nseq, input int unsigned pool);
		logic [15:0] picks [64][4];
		int unsigned nk [64];
		int unsigned ts;
		logic [2:0] op;
		ts = table_entries(cfg_wl);
		for (int s = 0; s < nseq; s++) begin
			nk[s] = $urandom_range(4, 1);
			for (int j = 0; j < nk[s]; j++) begin
				picks[s][j] = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(pool - 1));
				queue_item(OpCount, picks[s][j], 12'($urandom), 24'($urandom));
			end
		end
		queue_item(OpFinal, 16'($urandom), 12'($urandom), 24'($urandom));
		for (int s = 0; s < nseq; s++) begin
			for (int j = 0; j < nk[s]; j++)
				queue_item(OpAdd, picks[s][j], 12'($urandom), 24'($urandom));
			queue_item(OpEnd, 16'($urandom), 12'($urandom), 24'($urandom));
		end
		for (int q = 0; q < 2 * nseq; q++) begin
			case ($urandom_range(3))
				0: queue_item(OpQuery, 16'($urandom_range(pool - 1)),
						12'($urandom_range(nseq + 1)), 24'($urandom));
				1: queue_item(OpRdEnt, 16'($urandom_range(pool - 1)),
						12'($urandom_range(nseq)), 24'($urandom));
				2: queue_item(OpRdMap, 16'($urandom), 12'($urandom_range(nseq + 1)),
						24'($urandom));
				default: begin
					op = 3'($urandom);
					// A full finalize over a large table is too slow for noise.
					if (op == OpFinal && ts > 1024)
						op = OpQuery;
					queue_item(op, 16'($urandom), 12'($urandom), 24'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		int unsigned nseq, wl, sc;
		cfg_ub = 1'b1;
		cfg_wl = 4'd8;
		cfg_sc = '0;
		foreach (kcount[i]) begin
			kcount[i] = '0;
			kstart[i] = '0;
			kslot[i] = '0;
		end
		foreach (bitmap[i])
			bitmap[i] = '0;
		foreach (lstore[i])
			lstore[i] = '0;
		foreach (elem_seq[i])
			elem_seq[i] = '0;
		elem_no = 0;
		slots_taken = 0;
		built = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: wrong order, empty reads, the largest table and all slots taken.
		queue_item(3'd7, 16'hFFFF, 12'hFFF, 24'hFFFFFF);
		queue_item(OpRdMap, 16'h0, 12'h0, 24'h0);
		queue_item(OpAdd, 16'h0, 12'h0, 24'h0);
		queue_item(OpRdEnt, 16'h0, 12'h0, 24'h0);
		queue_item(OpEnd, 16'h0, 12'h0, 24'h000000);
		queue_item(OpRdMap, 16'h0, 12'h0, 24'h0);
		queue_item(OpCount, 16'h0000, 12'h0, 24'h0);
		queue_item(OpCount, 16'h0000, 12'h0, 24'h0);
		queue_item(OpCount, 16'hFFFF, 12'hFFF, 24'hFFFFFF);
		queue_item(OpFinal, 16'h0, 12'h0, 24'h0);
		queue_item(OpAdd, 16'h0000, 12'h0, 24'h0);
		queue_item(OpAdd, 16'hFFFF, 12'h0, 24'h0);
		queue_item(OpQuery, 16'h0000, 12'h0, 24'h0);
		queue_item(OpQuery, 16'hFFFF, 12'hFFF, 24'h0);
		queue_item(OpRdEnt, 16'h0000, 12'h0, 24'h0);
		queue_item(OpRdEnt, 16'hFFFF, 12'h0, 24'h0);
		queue_item(OpRdEnt, 16'hFFFF, 12'hFFF, 24'h0);
		queue_item(OpEnd, 16'h0, 12'h0, 24'hFFFFFF);
		queue_item(OpRdMap, 16'h0, 12'h0, 24'h0);
		queue_item(OpRdMap, 16'h0, 12'hFFF, 24'h0);
		drain();

		// A threshold above any count, and k-mers just outside a small table.
		configure(1'b0, 4'd1, 13'h1FFF);
		no_idle = 1'b1;
		for (int i = 0; i < 8; i++)
			queue_item(OpCount, 16'(i % 5), 12'($urandom), 24'($urandom));
		queue_item(OpFinal, 16'h0, 12'h0, 24'h0);
		for (int i = 0; i < 6; i++) begin
			queue_item(OpAdd, 16'($urandom_range(4)), 12'h0, 24'h0);
			queue_item(OpEnd, 16'h0, 12'h0, 24'($urandom));
		end
		queue_item(OpAdd, 16'h1, 12'h0, 24'h0);
		queue_item(OpRdMap, 16'h0, 12'hFFF, 24'h0);
		queue_item(OpRdEnt, 16'h0, 12'h1, 24'h0);
		drain();
		no_idle = 1'b0;

		// Random builds, mostly on small tables.
		while (queued < ItemTarget) begin
			if (queued > ItemTarget * 4 / 5)
				no_idle = 1'b1;
			nseq = $urandom_range(30, 3);
			wl = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(4, 1);
			if (table_entries(4'(wl)) > 1024 && $urandom_range(1) == 0)
				wl = $urandom_range(4, 1);
			case ($urandom_range(4))
				0: sc = 0;
				1: sc = 13'h1FFF;
				default: sc = $urandom_range(3 * nseq);
			endcase
			configure(1'($urandom), 4'(wl), 13'(sc));
			build_phase(nseq, (table_entries(4'(wl)) < 64) ? table_entries(4'(wl)) + 1 : 64);
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("kmer_inverted_index_builder_core verification clean");
		else
			$display("kmer_inverted_index_builder_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire
